// ===== hw/rtl/least_slack_multi_server_scheduler_macros.svh =====
// Assertion macros used by the scheduler checker.
`ifndef LEAST_SLACK_MULTI_SERVER_SCHEDULER_MACROS_SVH
`define LEAST_SLACK_MULTI_SERVER_SCHEDULER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define LSMS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsms: same-cycle property violated");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define LSMS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsms: next-cycle property violated");

`endif

// ===== hw/rtl/lsms_pkg.sv =====
package lsms_pkg;

    // Sizing of the job table, the server list and the time base.
    localparam int MAX_JOBS    = 128;
    localparam int MAX_SERVERS = 16;
    localparam int TIME_BITS   = 16;

    localparam int ID_W     = 7;
    localparam int JOB_AW   = $clog2(MAX_JOBS);
    localparam int SCAN_W   = JOB_AW + 1;
    localparam int PEND_W   = $clog2(MAX_JOBS + 1);
    localparam int SRV_CW   = $clog2(MAX_SERVERS + 1);
    localparam int SRV_AW   = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int SLACK_W  = TIME_BITS + 1;
    localparam int MEM_W    = 2 * TIME_BITS;
    localparam int STATUS_W = 2;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int CFG_W   = 5;
    localparam logic       CFG_SPT_IDX   = 1'b0;
    localparam logic [CFG_W-1:0] CFG_SPT_RESET = 5'd1;

    // Item kinds.
    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_SERVED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISSED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_IDLE   = 2'd2;

    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    typedef struct packed {
        logic                 kind;
        logic [ID_W-1:0]      job_id;
        logic [TIME_BITS-1:0] amount;
        logic [TIME_BITS-1:0] deadline;
    } req_t;

    typedef struct packed {
        logic [ID_W-1:0]      served_id;
        logic [TIME_BITS-1:0] slot_time;
        logic [STATUS_W-1:0]  status;
        logic                 all_done;
        logic                 last;
    } rsp_t;

endpackage

// ===== hw/rtl/least_slack_multi_server_scheduler.sv =====
// Least-slack multi-server scheduler. An add word with a nonzero amount stores a job
// (remaining slots and deadline) in a 128-entry table memory and returns nothing;
// req_ready is still high on the next cycle. A tick word yields 1 to 16 results, and a
// stall of the output register holds it up. The table memory's single read port is swept
// once, one entry per cycle, with registered read data. Meanwhile a 16-entry sorted list
// keeps the least-slack candidates. Then each service writes the decremented count back
// through the write port; a missed deadline ends the services early. Finally each result
// loads the output register when it is free. Results of a tick leave in order of slack,
// lowest id first on ties. They all carry the same all_done, and the final one is marked
// by last. Job valid bits sit in flip-flops, so the block is usable right after reset
// with no clearing pass. A new word is not taken until the previous tick has handed all
// of its results to the output register.
module least_slack_multi_server_scheduler
    import lsms_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  req_t               req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output rsp_t               rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_SERVE = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]     spt_reg, spt_next;
    logic [TIME_BITS-1:0] time_reg, time_next;
    logic                 missed_reg, missed_next;
    logic [MAX_JOBS-1:0]  job_valid_reg, job_valid_next;
    logic [PEND_W-1:0]    pend_reg, pend_next;

    // Table sweep.
    logic [SCAN_W-1:0] scan_addr_reg, scan_addr_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [JOB_AW-1:0] rd_id_reg, rd_id_next;

    // Sorted candidate list.
    logic signed [SLACK_W-1:0] cand_slack_reg [MAX_SERVERS];
    logic signed [SLACK_W-1:0] cand_slack_next [MAX_SERVERS];
    logic [JOB_AW-1:0]         cand_id_reg [MAX_SERVERS];
    logic [JOB_AW-1:0]         cand_id_next [MAX_SERVERS];
    logic [TIME_BITS-1:0]      cand_dl_reg [MAX_SERVERS];
    logic [TIME_BITS-1:0]      cand_dl_next [MAX_SERVERS];
    logic [TIME_BITS-1:0]      cand_rem_reg [MAX_SERVERS];
    logic [TIME_BITS-1:0]      cand_rem_next [MAX_SERVERS];
    logic [SRV_CW-1:0]         cand_cnt_reg, cand_cnt_next;

    // Service and result buffer.
    logic [SRV_CW-1:0]   svc_idx_reg, svc_idx_next;
    logic [ID_W-1:0]     res_id_reg [MAX_SERVERS];
    logic [ID_W-1:0]     res_id_next [MAX_SERVERS];
    logic [STATUS_W-1:0] res_st_reg [MAX_SERVERS];
    logic [STATUS_W-1:0] res_st_next [MAX_SERVERS];
    logic [SRV_CW-1:0]   res_cnt_reg, res_cnt_next;
    logic [SRV_CW-1:0]   emit_idx_reg, emit_idx_next;

    // Output register.
    rsp_t rsp_reg, rsp_next;
    logic rsp_valid_reg, rsp_valid_next;

    // Table memory: {remaining, deadline} per job.
    logic [MEM_W-1:0]  job_mem [MAX_JOBS];
    logic [MEM_W-1:0]  mem_rdata_reg;
    logic              mem_we;
    logic [JOB_AW-1:0] mem_waddr;
    logic [MEM_W-1:0]  mem_wdata;

    logic                      cfg_wr;
    logic [SRV_CW-1:0]         eff_limit;
    logic [SRV_CW-1:0]         n_use;
    logic [TIME_BITS-1:0]      new_rem;
    logic [TIME_BITS-1:0]      new_dl;
    logic signed [SLACK_W-1:0] new_slack;
    logic [MAX_SERVERS-1:0]    ins_lt;
    logic                      ins_en;
    logic [JOB_AW-1:0]         add_idx;
    logic                      add_ok;
    logic [SRV_AW-1:0]         svc_sel;
    logic [SRV_AW-1:0]         emit_sel;
    logic                      emit_last;
    logic                      load_ok;

    assign pready    = 1'b1;
    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Configuration register decode.
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_SPT_IDX);
    assign prdata = (paddr[2] == CFG_SPT_IDX) ? PDATA_W'(spt_reg) : '0;

    // Clamp the server count to 1..MAX_SERVERS.
    always_comb
    begin
        if (spt_reg == '0)
        begin
            eff_limit = SRV_CW'(1);
        end
        else if (32'(spt_reg) > MAX_SERVERS)
        begin
            eff_limit = SRV_CW'(MAX_SERVERS);
        end
        else
        begin
            eff_limit = SRV_CW'(spt_reg);
        end
    end

    assign n_use = (cand_cnt_reg < eff_limit) ? cand_cnt_reg : eff_limit;

    // Slack of the entry coming out of the memory.
    assign new_rem   = mem_rdata_reg[MEM_W-1:TIME_BITS];
    assign new_dl    = mem_rdata_reg[TIME_BITS-1:0];
    assign new_slack = $signed({1'b0, new_dl}) - $signed({1'b0, new_rem});
    assign ins_en    = (state_reg == ST_SCAN) && rd_pend_reg && job_valid_reg[rd_id_reg];

    // A new entry goes ahead of every entry with strictly larger slack; empty places
    // always take it. Equal slack keeps the earlier, lower id first.
    always_comb
    begin
        for (int j = 0; j < MAX_SERVERS; j++)
        begin
            ins_lt[j] = (SRV_CW'(j) >= cand_cnt_reg) || (new_slack < cand_slack_reg[j]);
        end
    end

    assign add_idx   = req.job_id[JOB_AW-1:0];
    assign add_ok    = (req.amount != '0) && (32'(req.job_id) < MAX_JOBS);
    assign svc_sel   = svc_idx_reg[SRV_AW-1:0];
    assign emit_sel  = emit_idx_reg[SRV_AW-1:0];
    assign emit_last = (SRV_CW'(emit_idx_reg + 1'b1) == res_cnt_reg);
    assign load_ok   = !rsp_valid_reg || rsp_ready;

    // Main control and datapath.
    always_comb
    begin
        state_next      = state_reg;
        spt_next        = spt_reg;
        time_next       = time_reg;
        missed_next     = missed_reg;
        job_valid_next  = job_valid_reg;
        pend_next       = pend_reg;
        scan_addr_next  = scan_addr_reg;
        rd_pend_next    = rd_pend_reg;
        rd_id_next      = rd_id_reg;
        cand_slack_next = cand_slack_reg;
        cand_id_next    = cand_id_reg;
        cand_dl_next    = cand_dl_reg;
        cand_rem_next   = cand_rem_reg;
        cand_cnt_next   = cand_cnt_reg;
        svc_idx_next    = svc_idx_reg;
        res_id_next     = res_id_reg;
        res_st_next     = res_st_reg;
        res_cnt_next    = res_cnt_reg;
        emit_idx_next   = emit_idx_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;

        if (cfg_wr)
        begin
            spt_next = pwdata[CFG_W-1:0];
        end

        // The output register empties when its word is taken.
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.kind == KIND_ADD)
                    begin
                        if (add_ok)
                        begin
                            mem_we                  = 1'b1;
                            mem_waddr               = add_idx;
                            mem_wdata               = {req.amount, req.deadline};
                            job_valid_next[add_idx] = 1'b1;
                            if (!job_valid_reg[add_idx])
                            begin
                                pend_next = PEND_W'(pend_reg + 1'b1);
                            end
                        end
                    end
                    else
                    begin
                        scan_addr_next = '0;
                        rd_pend_next   = 1'b0;
                        cand_cnt_next  = '0;
                        svc_idx_next   = '0;
                        state_next     = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // Issue one read per cycle across the table.
                if (scan_addr_reg < SCAN_W'(MAX_JOBS))
                begin
                    scan_addr_next = SCAN_W'(scan_addr_reg + 1'b1);
                    rd_pend_next   = 1'b1;
                    rd_id_next     = scan_addr_reg[JOB_AW-1:0];
                end
                else
                begin
                    rd_pend_next = 1'b0;
                end

                // Insert the returned entry into the sorted list.
                if (ins_en)
                begin
                    if (ins_lt[0])
                    begin
                        cand_slack_next[0] = new_slack;
                        cand_id_next[0]    = rd_id_reg;
                        cand_dl_next[0]    = new_dl;
                        cand_rem_next[0]   = new_rem;
                    end
                    for (int j = 1; j < MAX_SERVERS; j++)
                    begin
                        if (ins_lt[j] && !ins_lt[j-1])
                        begin
                            cand_slack_next[j] = new_slack;
                            cand_id_next[j]    = rd_id_reg;
                            cand_dl_next[j]    = new_dl;
                            cand_rem_next[j]   = new_rem;
                        end
                        else if (ins_lt[j])
                        begin
                            cand_slack_next[j] = cand_slack_reg[j-1];
                            cand_id_next[j]    = cand_id_reg[j-1];
                            cand_dl_next[j]    = cand_dl_reg[j-1];
                            cand_rem_next[j]   = cand_rem_reg[j-1];
                        end
                    end
                    if (32'(cand_cnt_reg) < MAX_SERVERS)
                    begin
                        cand_cnt_next = SRV_CW'(cand_cnt_reg + 1'b1);
                    end
                end

                if ((scan_addr_reg == SCAN_W'(MAX_JOBS)) && !rd_pend_reg)
                begin
                    state_next = ST_SERVE;
                end
            end

            ST_SERVE:
            begin
                if (svc_idx_reg == n_use)
                begin
                    // Every chosen job was served, or nothing was pending.
                    if (svc_idx_reg == '0)
                    begin
                        res_id_next[0] = '0;
                        res_st_next[0] = STATUS_IDLE;
                        res_cnt_next   = SRV_CW'(1);
                    end
                    else
                    begin
                        res_cnt_next = svc_idx_reg;
                    end
                    emit_idx_next = '0;
                    state_next    = ST_EMIT;
                end
                else if (cand_dl_reg[svc_sel] <= time_reg)
                begin
                    // Deadline reached: report the miss and end the tick.
                    res_id_next[svc_sel] = ID_W'(cand_id_reg[svc_sel]);
                    res_st_next[svc_sel] = STATUS_MISSED;
                    missed_next          = 1'b1;
                    res_cnt_next         = SRV_CW'(svc_idx_reg + 1'b1);
                    emit_idx_next        = '0;
                    state_next           = ST_EMIT;
                end
                else
                begin
                    // Serve one slot and write the count back.
                    res_id_next[svc_sel] = ID_W'(cand_id_reg[svc_sel]);
                    res_st_next[svc_sel] = missed_reg ? STATUS_MISSED : STATUS_SERVED;
                    mem_we               = 1'b1;
                    mem_waddr            = cand_id_reg[svc_sel];
                    mem_wdata            = {TIME_BITS'(cand_rem_reg[svc_sel] - 1'b1),
                                            cand_dl_reg[svc_sel]};
                    if (cand_rem_reg[svc_sel] == TIME_BITS'(1))
                    begin
                        job_valid_next[cand_id_reg[svc_sel]] = 1'b0;
                        pend_next = PEND_W'(pend_reg - 1'b1);
                    end
                    svc_idx_next = SRV_CW'(svc_idx_reg + 1'b1);
                end
            end

            ST_EMIT:
            begin
                if (load_ok)
                begin
                    rsp_next.served_id = res_id_reg[emit_sel];
                    rsp_next.slot_time = time_reg;
                    rsp_next.status    = res_st_reg[emit_sel];
                    rsp_next.all_done  = (pend_reg == '0);
                    rsp_next.last      = emit_last;
                    rsp_valid_next     = 1'b1;
                    if (emit_last)
                    begin
                        if (time_reg != TIME_MAX)
                        begin
                            time_next = TIME_BITS'(time_reg + 1'b1);
                        end
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        emit_idx_next = SRV_CW'(emit_idx_reg + 1'b1);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            spt_reg       <= CFG_SPT_RESET;
            time_reg      <= '0;
            missed_reg    <= 1'b0;
            job_valid_reg <= '0;
            pend_reg      <= '0;
            scan_addr_reg <= '0;
            rd_pend_reg   <= 1'b0;
            cand_cnt_reg  <= '0;
            svc_idx_reg   <= '0;
            res_cnt_reg   <= '0;
            emit_idx_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            spt_reg       <= spt_next;
            time_reg      <= time_next;
            missed_reg    <= missed_next;
            job_valid_reg <= job_valid_next;
            pend_reg      <= pend_next;
            scan_addr_reg <= scan_addr_next;
            rd_pend_reg   <= rd_pend_next;
            cand_cnt_reg  <= cand_cnt_next;
            svc_idx_reg   <= svc_idx_next;
            res_cnt_reg   <= res_cnt_next;
            emit_idx_reg  <= emit_idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rd_id_reg      <= rd_id_next;
        cand_slack_reg <= cand_slack_next;
        cand_id_reg    <= cand_id_next;
        cand_dl_reg    <= cand_dl_next;
        cand_rem_reg   <= cand_rem_next;
        res_id_reg     <= res_id_next;
        res_st_reg     <= res_st_next;
        rsp_reg        <= rsp_next;
    end

    // Job table memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            job_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= job_mem[scan_addr_reg[JOB_AW-1:0]];
    end

endmodule

// ===== hw/rtl/lsms_checker.sv =====
`include "least_slack_multi_server_scheduler_macros.svh"

module lsms_checker
    import lsms_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    logic seen_miss_reg;

    // Remember that a missed deadline has been reported.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_miss_reg <= 1'b0;
        end
        else if (rsp_valid && rsp_ready && (rsp.status == STATUS_MISSED))
        begin
            seen_miss_reg <= 1'b1;
        end
    end

    // An idle result stands alone and names job zero.
    `LSMS_ASSERT_IMP(a_idle_alone, clk, rst_n, rsp_valid && (rsp.status == STATUS_IDLE), rsp.last && (rsp.served_id == '0))

    // The first miss always closes its tick; later services only repeat the sticky status.
    `LSMS_ASSERT_IMP(a_miss_ends_tick, clk, rst_n, rsp_valid && !seen_miss_reg && (rsp.status == STATUS_MISSED), rsp.last)

    // Once a miss was reported, no later word reports a clean service.
    `LSMS_ASSERT_IMP(a_miss_sticky, clk, rst_n, rsp_valid && seen_miss_reg, rsp.status != STATUS_SERVED)

    // A tick word starts a table sweep, so no word is taken in the next cycle.
    `LSMS_ASSERT_NEXT(a_tick_busy, clk, rst_n, req_valid && req_ready && (req.kind == KIND_TICK), !req_ready)

    // A stalled result word holds.
    `LSMS_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

endmodule

bind least_slack_multi_server_scheduler lsms_checker u_lsms_checker (.*);
